/* design/lztsd_pkg.sv */
// Package: shared widths and constants for the token stream decoder.
`default_nettype none
package lztsd_pkg;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned OUT_W   = 64;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned TOTAL_W = 24;
  localparam int unsigned LIT_W   = 17;
  localparam int unsigned DIST_W  = 17;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned MCNT_W  = 4;
  localparam int unsigned PH_W    = 4;

  localparam logic [LIT_W-1:0]   LIT_DROP_MATCH = 17'h1011D;
  localparam logic [4:0]         EXT_ONE_BYTE   = 5'h1E;
  localparam logic [4:0]         EXT_TWO_BYTE   = 5'h1F;
  localparam logic [LEN_W-1:0]   LEN_EXT_BASE   = 9'd7;
  localparam logic [LIT_W-1:0]   EXT_HI_BIAS    = 17'hFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX      = 24'hFFFFFF;
endpackage
`default_nettype wire

/* design/lztsd_in_if.sv */
// Interfaces: compressed byte input channel and decoded result channel.
`default_nettype none
interface lztsd_in_if;
  logic                          valid;
  logic                          ready;
  logic [lztsd_pkg::BYTE_W-1:0]  in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lztsd_out_if;
  logic                          valid;
  logic                          ready;
  logic [lztsd_pkg::OUT_W-1:0]   out_bytes;
  logic [lztsd_pkg::CNT_W-1:0]   out_count;
  logic                          last_of_run;
  logic                          end_of_stream;
  logic [lztsd_pkg::TOTAL_W-1:0] total_length;
  modport source (output valid, output out_bytes, output out_count, output last_of_run,
                  output end_of_stream, output total_length, input ready);
  modport sink   (input valid, input out_bytes, input out_count, input last_of_run,
                  input end_of_stream, input total_length, output ready);
endinterface
`default_nettype wire

/* design/lz_token_stream_decoder.sv */
// Top level: byte-serial LZ77 token decoder around a synchronous history memory.
// Header bytes are accepted while parsing; a literal byte is accepted only when the output slot is free.
// A match is copied through the history memory byte by byte (read, then write),
// and input is held until the copy is done, including any output stall.
// Results leave through a single output register; the copy pauses while it is full and a result is due.
// Reset clears all control state; history memory is not cleared and holds no valid bits.
`default_nettype none
module lz_token_stream_decoder #(
  parameter int unsigned HISTORY_DEPTH    = 131072,
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lztsd_in_if.sink   in_i,
  lztsd_out_if.source out_o
);
  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam logic [lztsd_pkg::CNT_W-1:0] CHUNK = lztsd_pkg::CNT_W'(BYTES_PER_RESULT);

  localparam logic [1:0] S_PARSE = 2'd0;
  localparam logic [1:0] S_RD    = 2'd1;
  localparam logic [1:0] S_WR    = 2'd2;

  localparam logic [3:0] PH_TOKEN    = 4'd0;
  localparam logic [3:0] PH_LIT_EXT  = 4'd1;
  localparam logic [3:0] PH_LIT_LO   = 4'd2;
  localparam logic [3:0] PH_LIT_HI   = 4'd3;
  localparam logic [3:0] PH_LITERAL  = 4'd4;
  localparam logic [3:0] PH_MATCH    = 4'd5;
  localparam logic [3:0] PH_LEN_EXT  = 4'd6;
  localparam logic [3:0] PH_DIST_EXT = 4'd7;
  localparam logic [3:0] PH_DIST_LO  = 4'd8;
  localparam logic [3:0] PH_DIST_HI  = 4'd9;

  logic [7:0] hist_mem [HISTORY_DEPTH];
  logic [7:0] rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd;

  logic [1:0]  state_q, state_d;
  logic [lztsd_pkg::PH_W-1:0]    phase_q, phase_d;
  logic [AW-1:0]                 wp_q, wp_d, src_q, src_d;
  logic [lztsd_pkg::LIT_W-1:0]   lit_q, lit_d;
  logic [lztsd_pkg::MCNT_W-1:0]  ml_q, ml_d;
  logic [lztsd_pkg::LEN_W-1:0]   len_q, len_d;
  logic [lztsd_pkg::DIST_W-1:0]  dist_q, dist_d;
  logic [7:0]                    extlo_q, extlo_d;
  logic [lztsd_pkg::TOTAL_W-1:0] prod_q, prod_d;
  logic [lztsd_pkg::OUT_W-1:0]   acc_q, acc_d;
  logic [lztsd_pkg::CNT_W-1:0]   fill_q, fill_d;

  logic                          ov_q, ov_d, ol_q, ol_d, oe_q, oe_d;
  logic [lztsd_pkg::OUT_W-1:0]   ob_q, ob_d;
  logic [lztsd_pkg::CNT_W-1:0]   oc_q, oc_d;
  logic [lztsd_pkg::TOTAL_W-1:0] ot_q, ot_d;

  logic in_ready, in_fire, out_free;
  logic [7:0] b;

  assign b        = in_i.in_byte;
  assign out_free = !ov_q || out_o.ready;
  assign in_ready = (state_q == S_PARSE) &&
                    (!(phase_q == PH_LITERAL || phase_q == PH_LEN_EXT) || out_free);
  assign in_fire  = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  assign out_o.valid         = ov_q;
  assign out_o.out_bytes     = ob_q;
  assign out_o.out_count     = oc_q;
  assign out_o.last_of_run   = ol_q;
  assign out_o.end_of_stream = oe_q;
  assign out_o.total_length  = ot_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) hist_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= hist_mem[mem_ra];
  end

  always_comb begin
    logic                         start_match, after_count, emit_now, clear;
    logic [lztsd_pkg::LIT_W-1:0]  lit_v;
    logic [lztsd_pkg::MCNT_W-1:0] ml_v;
    logic [lztsd_pkg::DIST_W-1:0] dist_v;
    logic [AW:0]                  sub_v;
    logic [lztsd_pkg::CNT_W-1:0]  fill_n;

    start_match = 1'b0;
    after_count = 1'b0;
    emit_now    = 1'b0;
    clear       = 1'b0;
    lit_v  = lit_q;
    ml_v   = ml_q;
    dist_v = dist_q;
    sub_v  = '0;
    fill_n = fill_q + 1'b1;

    state_d = state_q;  phase_d = phase_q; wp_d = wp_q;   src_d = src_q;
    len_d   = len_q;    extlo_d = extlo_q; prod_d = prod_q;
    acc_d   = acc_q;    fill_d  = fill_q;
    ov_d = ov_q; ob_d = ob_q; oc_d = oc_q; ol_d = ol_q; oe_d = oe_q; ot_d = ot_q;
    mem_we = 1'b0; mem_re = 1'b0;
    mem_wa = wp_q; mem_ra = src_q; mem_wd = b;

    if (ov_q && out_o.ready) ov_d = 1'b0;

    unique case (state_q)
      S_PARSE: begin
        if (in_fire) begin
          unique case (phase_q)
            PH_LIT_EXT: begin
              lit_v = lztsd_pkg::LIT_W'(30) + lztsd_pkg::LIT_W'(b);
              after_count = 1'b1;
            end
            PH_LIT_LO: begin
              extlo_d = b;
              phase_d = PH_LIT_HI;
            end
            PH_LIT_HI: begin
              lit_v = lztsd_pkg::LIT_W'(31) + lztsd_pkg::LIT_W'(extlo_q)
                    + {1'b0, b, 8'h00} + lztsd_pkg::EXT_HI_BIAS;
              after_count = 1'b1;
            end
            PH_LITERAL: begin
              mem_we = 1'b1;
              wp_d   = (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
              if (prod_q != lztsd_pkg::TOTAL_MAX) prod_d = prod_q + 1'b1;
              ov_d = 1'b1; ob_d = lztsd_pkg::OUT_W'(b); oc_d = lztsd_pkg::CNT_W'(1);
              ol_d = 1'b1; oe_d = 1'b0; ot_d = '0;
              lit_v = lit_q - 1'b1;
              if (lit_v == '0) phase_d = (ml_q != '0) ? PH_MATCH : PH_TOKEN;
            end
            PH_MATCH: begin
              len_d  = lztsd_pkg::LEN_W'(b[2:0]);
              dist_v = lztsd_pkg::DIST_W'(b[7:3]);
              if (b[2:0] == 3'd0)               phase_d = PH_LEN_EXT;
              else if (b[7:3] == lztsd_pkg::EXT_ONE_BYTE) phase_d = PH_DIST_EXT;
              else if (b[7:3] == lztsd_pkg::EXT_TWO_BYTE) phase_d = PH_DIST_LO;
              else start_match = 1'b1;
            end
            PH_LEN_EXT: begin
              if (b == 8'd0) begin
                ov_d = 1'b1; ob_d = '0; oc_d = '0; ol_d = 1'b1; oe_d = 1'b1; ot_d = prod_q;
                clear = 1'b1;
              end else begin
                len_d = lztsd_pkg::LEN_W'(b) + lztsd_pkg::LEN_EXT_BASE;
                if (dist_q == lztsd_pkg::DIST_W'(lztsd_pkg::EXT_ONE_BYTE))
                  phase_d = PH_DIST_EXT;
                else if (dist_q == lztsd_pkg::DIST_W'(lztsd_pkg::EXT_TWO_BYTE))
                  phase_d = PH_DIST_LO;
                else start_match = 1'b1;
              end
            end
            PH_DIST_EXT: begin
              dist_v = lztsd_pkg::DIST_W'(30) + lztsd_pkg::DIST_W'(b);
              start_match = 1'b1;
            end
            PH_DIST_LO: begin
              extlo_d = b;
              phase_d = PH_DIST_HI;
            end
            PH_DIST_HI: begin
              dist_v = lztsd_pkg::DIST_W'(31) + lztsd_pkg::DIST_W'(extlo_q)
                     + {1'b0, b, 8'h00} + lztsd_pkg::EXT_HI_BIAS;
              start_match = 1'b1;
            end
            default: begin
              lit_v = lztsd_pkg::LIT_W'(b[7:3]);
              ml_v  = lztsd_pkg::MCNT_W'(b[2:0]) + 1'b1;
              if (b[7:3] == lztsd_pkg::EXT_ONE_BYTE)      phase_d = PH_LIT_EXT;
              else if (b[7:3] == lztsd_pkg::EXT_TWO_BYTE) phase_d = PH_LIT_LO;
              else after_count = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_WR;
      end
      default: begin
        emit_now = (fill_n == CHUNK) || (len_q == lztsd_pkg::LEN_W'(1));
        if (!emit_now || out_free) begin
          mem_we = 1'b1;
          mem_wd = rd_q;
          wp_d   = (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
          src_d  = (src_q == LAST_ADDR) ? '0 : src_q + 1'b1;
          if (prod_q != lztsd_pkg::TOTAL_MAX) prod_d = prod_q + 1'b1;
          len_d = len_q - 1'b1;
          acc_d = acc_q;
          acc_d[8*fill_q[2:0] +: 8] = rd_q;
          fill_d = fill_n;
          if (emit_now) begin
            ov_d = 1'b1; ob_d = acc_d; oc_d = fill_n; ol_d = (len_q == lztsd_pkg::LEN_W'(1));
            oe_d = 1'b0; ot_d = '0;
            acc_d = '0; fill_d = '0;
          end
          if (len_q == lztsd_pkg::LEN_W'(1)) begin
            if (ml_q != '0) ml_v = ml_q - 1'b1;
            phase_d = (ml_v != '0) ? PH_MATCH : PH_TOKEN;
            state_d = S_PARSE;
          end else begin
            state_d = S_RD;
          end
        end
      end
    endcase

    if (after_count) begin
      if (lit_v == lztsd_pkg::LIT_DROP_MATCH && ml_v != '0) ml_v = ml_v - 1'b1;
      if (lit_v != '0)      phase_d = PH_LITERAL;
      else if (ml_v != '0)  phase_d = PH_MATCH;
      else                  phase_d = PH_TOKEN;
    end

    if (start_match) begin
      // source = write position - distance - 1, wrapped into the history
      sub_v = {1'b0, wp_q} - (AW+1)'(dist_v) - 1'b1;
      src_d = sub_v[AW] ? AW'(sub_v + (AW+1)'(HISTORY_DEPTH)) : sub_v[AW-1:0];
      acc_d = '0;
      fill_d = '0;
      state_d = S_RD;
    end

    lit_d = lit_v; ml_d = ml_v; dist_d = dist_v;

    if (clear) begin
      wp_d = '0; phase_d = PH_TOKEN; lit_d = '0; ml_d = '0; len_d = '0;
      dist_d = '0; extlo_d = '0; prod_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_PARSE; phase_q <= PH_TOKEN; wp_q <= '0; src_q <= '0;
      lit_q <= '0; ml_q <= '0; len_q <= '0; dist_q <= '0; extlo_q <= '0;
      prod_q <= '0; acc_q <= '0; fill_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; phase_q <= phase_d; wp_q <= wp_d; src_q <= src_d;
      lit_q <= lit_d; ml_q <= ml_d; len_q <= len_d; dist_q <= dist_d; extlo_q <= extlo_d;
      prod_q <= prod_d; acc_q <= acc_d; fill_q <= fill_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d; oc_q <= oc_d; ol_q <= ol_d; oe_q <= oe_d; ot_q <= ot_d;
  end

`ifndef NO_ASSERTIONS
  a_no_accept_in_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> state_q == S_PARSE) else $error("input taken during match copy");
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR |-> $past(state_q) == S_RD || $past(state_q) == S_WR)
    else $error("history write without read");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CHUNK) else $error("chunk fill overrun");
  a_eos_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && oe_q |-> oc_q == '0 && ol_q) else $error("end marker carries bytes");
`endif
endmodule
`default_nettype wire

/* bench/lztsd_scoreboard.sv */
// Scoreboard: decoder prediction and result checking for the token stream decoder.
`default_nettype none
package lztsd_sb_pkg;
  import lztsd_pkg::*;

  localparam int unsigned HIST_DEPTH = 131072;
  localparam int unsigned CHUNK      = 8;

  typedef enum logic [3:0] {
    ST_TOKEN, ST_LIT_EXT, ST_LIT_LO, ST_LIT_HI, ST_LITERAL,
    ST_MATCH, ST_LEN_EXT, ST_DIST_EXT, ST_DIST_LO, ST_DIST_HI
  } parse_st_e;

  typedef struct {
    logic [OUT_W-1:0]   bytes;
    logic [CNT_W-1:0]   count;
    logic               last;
    logic               eos;
    logic [TOTAL_W-1:0] total;
  } chunk_t;

  class decode_scoreboard;
    logic [BYTE_W-1:0]  hist [HIST_DEPTH];
    int unsigned        wr_pos;
    parse_st_e          st;
    int unsigned        lit_left;
    int unsigned        match_left;
    int unsigned        m_len;
    int unsigned        m_dist;
    int unsigned        ext_lo;
    logic [TOTAL_W-1:0] produced;
    chunk_t             pending_q[$];
    chunk_t             step_q[$];
    int                 errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      wr_pos = 0;
      st = ST_TOKEN;
      lit_left = 0;
      match_left = 0;
      m_len = 0;
      m_dist = 0;
      ext_lo = 0;
      produced = '0;
    endfunction

    function void put(logic [BYTE_W-1:0] b);
      hist[wr_pos] = b;
      wr_pos = (wr_pos + 1) % HIST_DEPTH;
      if (produced != TOTAL_MAX) produced++;
    endfunction

    function void push(logic [OUT_W-1:0] bytes, int unsigned cnt, logic eos,
                       logic [TOTAL_W-1:0] total);
      chunk_t c;
      c.bytes = bytes;
      c.count = cnt[CNT_W-1:0];
      c.last = 1'b0;
      c.eos = eos;
      c.total = total;
      step_q.push_back(c);
    endfunction

    function void literal_count_done();
      if (lit_left == int'(LIT_DROP_MATCH) && match_left > 0) match_left--;
      if (lit_left > 0) st = ST_LITERAL;
      else if (match_left > 0) st = ST_MATCH;
      else st = ST_TOKEN;
    endfunction

    function void copy_match();
      int unsigned      src;
      int unsigned      fill;
      logic [OUT_W-1:0] acc;
      logic [BYTE_W-1:0] b;
      src = (wr_pos + HIST_DEPTH - (m_dist % HIST_DEPTH) - 1) % HIST_DEPTH;
      fill = 0;
      acc = '0;
      for (int unsigned i = 0; i < m_len; i++) begin
        b = hist[src];
        put(b);
        src = (src + 1) % HIST_DEPTH;
        acc |= OUT_W'(b) << (8 * fill);
        fill++;
        if (fill == CHUNK) begin
          push(acc, fill, 1'b0, '0);
          acc = '0;
          fill = 0;
        end
      end
      if (fill > 0) push(acc, fill, 1'b0, '0);
      if (match_left > 0) match_left--;
      st = (match_left > 0) ? ST_MATCH : ST_TOKEN;
    endfunction

    function void dist_or_copy();
      if (m_dist == EXT_ONE_BYTE) st = ST_DIST_EXT;
      else if (m_dist == EXT_TWO_BYTE) st = ST_DIST_LO;
      else copy_match();
    endfunction

    // Note one accepted compressed byte and queue the chunks it causes.
    function void note_byte(logic [BYTE_W-1:0] b);
      step_q.delete();
      case (st)
        ST_LIT_EXT: begin
          lit_left = 30 + b;
          literal_count_done();
        end
        ST_LIT_LO: begin
          ext_lo = b;
          st = ST_LIT_HI;
        end
        ST_LIT_HI: begin
          lit_left = 31 + ext_lo + b * 256 + int'(EXT_HI_BIAS);
          literal_count_done();
        end
        ST_LITERAL: begin
          put(b);
          push(OUT_W'(b), 1, 1'b0, '0);
          if (lit_left > 0) lit_left--;
          if (lit_left == 0) st = (match_left > 0) ? ST_MATCH : ST_TOKEN;
        end
        ST_MATCH: begin
          m_len = b[2:0];
          m_dist = b[7:3];
          if (m_len == 0) st = ST_LEN_EXT;
          else dist_or_copy();
        end
        ST_LEN_EXT: begin
          if (b == 0) begin
            push('0, 0, 1'b1, produced);
            clear();
          end else begin
            m_len = b + int'(LEN_EXT_BASE);
            dist_or_copy();
          end
        end
        ST_DIST_EXT: begin
          m_dist = 30 + b;
          copy_match();
        end
        ST_DIST_LO: begin
          ext_lo = b;
          st = ST_DIST_HI;
        end
        ST_DIST_HI: begin
          m_dist = 31 + ext_lo + b * 256 + int'(EXT_HI_BIAS);
          copy_match();
        end
        default: begin
          lit_left = b[7:3];
          match_left = b[2:0] + 1;
          if (lit_left == EXT_ONE_BYTE) st = ST_LIT_EXT;
          else if (lit_left == EXT_TWO_BYTE) st = ST_LIT_LO;
          else literal_count_done();
        end
      endcase
      if (step_q.size() > 0) step_q[$].last = 1'b1;
      foreach (step_q[i]) pending_q.push_back(step_q[i]);
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void check(chunk_t got);
      chunk_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result bytes=%h count=%0d", got.bytes, got.count));
        return;
      end
      want = pending_q.pop_front();
      if (got.bytes !== want.bytes)
        report($sformatf("out_bytes %h, want %h", got.bytes, want.bytes));
      if (got.count !== want.count)
        report($sformatf("out_count %0d, want %0d", got.count, want.count));
      if (got.last !== want.last)
        report($sformatf("last_of_run %b, want %b", got.last, want.last));
      if (got.eos !== want.eos)
        report($sformatf("end_of_stream %b, want %b", got.eos, want.eos));
      if (got.total !== want.total)
        report($sformatf("total_length %0d, want %0d", got.total, want.total));
    endfunction
  endclass
endpackage
`default_nettype wire

/* bench/tb.sv */
// Testbench top: drives compressed streams into the decoder and checks every result.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lztsd_pkg::*;
  import lztsd_sb_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_AT     = 200;
  localparam int unsigned HOLD_LEN    = 400;
  localparam int unsigned RANDOM_ITEMS = 45;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lztsd_in_if  in_ch();
  lztsd_out_if out_ch();

  lz_token_stream_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  decode_scoreboard sb = new();
  logic [BYTE_W-1:0] stream_q[$];
  int unsigned gen_wp = 0;
  int unsigned cyc = 0;
  int unsigned quiet = 0;
  logic        send_done = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    out_ch.ready = 1'b0;
  end

  // Keep a stretch without idling on both sides.
  function automatic bit idle_now();
    if (cyc > 650 && cyc < 950) return 1'b0;
    return $urandom_range(0, 99) < 12;
  endfunction

  // Encode a token with its literal count and random literal bytes.
  task automatic gen_token(int unsigned lits, int unsigned nmatch);
    int unsigned v;
    if (lits < 30) begin
      stream_q.push_back({5'(lits), 3'(nmatch - 1)});
    end else if (lits < 286) begin
      stream_q.push_back({EXT_ONE_BYTE, 3'(nmatch - 1)});
      stream_q.push_back(8'(lits - 30));
    end else begin
      v = lits - 286;
      stream_q.push_back({EXT_TWO_BYTE, 3'(nmatch - 1)});
      stream_q.push_back(v[7:0]);
      stream_q.push_back(v[15:8]);
    end
    repeat (lits) stream_q.push_back(8'($urandom_range(0, 255)));
    gen_wp += lits;
  endtask

  // Encode a match; gap must stay below the bytes written in this stream.
  task automatic gen_match(int unsigned len, int unsigned gap);
    int unsigned v;
    logic [4:0]  code;
    code = (gap < 30) ? 5'(gap) : (gap < 286) ? EXT_ONE_BYTE : EXT_TWO_BYTE;
    stream_q.push_back({code, (len <= 7) ? 3'(len) : 3'd0});
    if (len > 7) stream_q.push_back(8'(len - 7));
    if (code == EXT_ONE_BYTE) stream_q.push_back(8'(gap - 30));
    if (code == EXT_TWO_BYTE) begin
      v = gap - 286;
      stream_q.push_back(v[7:0]);
      stream_q.push_back(v[15:8]);
    end
    gen_wp += len;
  endtask

  task automatic gen_end();
    stream_q.push_back({5'($urandom_range(0, 31)), 3'd0});
    stream_q.push_back(8'd0);
    gen_wp = 0;
  endtask

  task automatic gen_random_stream();
    int unsigned ntok, nm, stop_at, lits, len, gap;
    ntok = $urandom_range(1, 4);
    for (int t = 0; t < ntok; t++) begin
      if (gen_wp == 0) lits = $urandom_range(1, 8);
      else if ($urandom_range(0, 9) < 8) lits = $urandom_range(0, 8);
      else lits = $urandom_range(30, 40);
      nm = $urandom_range(1, 8);
      stop_at = (t == ntok - 1) ? $urandom_range(0, nm - 1) : nm;
      gen_token(lits, nm);
      for (int m = 0; m < nm; m++) begin
        if (m == stop_at) begin
          gen_end();
          return;
        end
        len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 7) : $urandom_range(8, 40);
        if ($urandom_range(0, 1) == 0 && gen_wp > 30) gap = $urandom_range(0, 29);
        else gap = $urandom_range(0, gen_wp - 1);
        gen_match(len, gap);
      end
    end
  endtask

  task automatic build_stimulus();
    int unsigned base;
    // Extremes: zero and all-ones literals, shortest and longest matches, every
    // distance encoding, a token without literals, and the one-byte literal extension.
    stream_q.push_back({5'd3, 3'd3});
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hFF);
    stream_q.push_back(8'h5A);
    gen_wp = 3;
    gen_match(1, 0);
    gen_match(7, 2);
    gen_match(8, 0);
    gen_match(262, 9);
    gen_token(30, 1);
    gen_match(5, 285);
    gen_token(0, 1);
    gen_match(2, 1);
    gen_token(2, 2);
    gen_match(3, 286);
    gen_match(9, 300);
    gen_token(2, 1);
    gen_end();
    base = stream_q.size();
    while (stream_q.size() < base + RANDOM_ITEMS) gen_random_stream();
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) begin
      while (idle_now()) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
      end
      @(negedge clk_i);
      in_ch.valid <= 1'b1;
      in_ch.in_byte <= stream_q[i];
      do @(posedge clk_i); while (!in_ch.ready);
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  // Note every accepted request and advance the idle watchdog.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.in_byte);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else if (rst_ni) quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    chunk_t got;
    if (out_ch.valid && out_ch.ready) begin
      got.bytes = out_ch.out_bytes;
      got.count = out_ch.out_count;
      got.last = out_ch.last_of_run;
      got.eos = out_ch.end_of_stream;
      got.total = out_ch.total_length;
      sb.check(got);
    end
  end

  // Receiver: random stalls plus one long hold-off so the decoder backs up.
  initial begin
    int unsigned hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (cyc == HOLD_AT) hold = HOLD_LEN;
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !idle_now();
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_stream();
    while (sb.pending_q.size() > 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
